@@ rtl/tkd_pkg.sv @@
// ----------------------------------------------------------------------------
// tkd_pkg
// Shared types, constants and the page character table of the touch
// keyboard decoder.
// ----------------------------------------------------------------------------
package tkd_pkg;

	// text store depth default
	localparam int TKD_TEXT_DEPTH = 64;

	// field widths
	localparam int COORD_W = 9;
	localparam int KEY_W   = 5;
	localparam int PAGE_W  = 3;
	localparam int CHAR_W  = 7;
	localparam int POS_W   = 6;
	localparam int LEN_W   = 7;
	localparam int CFG_IDX_W = 3;

	// key geometry
	localparam logic [COORD_W-1:0] KEY_WIDTH = COORD_W'(30);
	localparam int MAX_COL = 4;
	localparam int MAX_KEY = 20;

	// special keys
	localparam logic [KEY_W-1:0] KEY_NONE   = KEY_W'(0);
	localparam logic [KEY_W-1:0] KEY_PAGE   = KEY_W'(15);
	localparam logic [KEY_W-1:0] KEY_TYPE   = KEY_W'(16);
	localparam logic [KEY_W-1:0] KEY_DELETE = KEY_W'(17);

	localparam logic [CHAR_W-1:0] UNKNOWN_CHAR = CHAR_W'("?");

	// keyboard pages
	localparam logic [PAGE_W-1:0] PAGE_1 = PAGE_W'(1);
	localparam logic [PAGE_W-1:0] PAGE_2 = PAGE_W'(2);
	localparam logic [PAGE_W-1:0] PAGE_3 = PAGE_W'(3);
	localparam logic [PAGE_W-1:0] PAGE_4 = PAGE_W'(4);
	localparam logic [PAGE_W-1:0] PAGE_5 = PAGE_W'(5);
	localparam logic [PAGE_W-1:0] PAGE_6 = PAGE_W'(6);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_AREA_LEFT    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_AREA_RIGHT   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_ONE_BOTTOM   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_TWO_BOTTOM   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_THREE_BOTTOM = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_FOUR_BOTTOM  = CFG_IDX_W'(5);

	// event codes
	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_CHAR   = 3'd1,
		EV_DELETE = 3'd2,
		EV_PAGE   = 3'd3,
		EV_FULL   = 3'd4,
		EV_EMPTY  = 3'd5
	} event_t;

	// configuration register set
	typedef struct packed {
		logic [COORD_W-1:0] key_area_left;
		logic [COORD_W-1:0] key_area_right;
		logic [COORD_W-1:0] row_one_bottom;
		logic [COORD_W-1:0] row_two_bottom;
		logic [COORD_W-1:0] row_three_bottom;
		logic [COORD_W-1:0] row_four_bottom;
	} tkd_cfg_t;

	// one result item
	typedef struct packed {
		event_t             event_kind;
		logic [CHAR_W-1:0]  char_code;
		logic [POS_W-1:0]   write_position;
		logic [LEN_W-1:0]   text_length;
		logic [PAGE_W-1:0]  page_now;
	} tkd_result_t;

	// page table, one 21-char row per page, key index 0 leftmost
	localparam int ROW_CHARS = MAX_KEY + 1;
	localparam int ROW_BITS  = ROW_CHARS * 8;
	localparam logic [ROW_BITS-1:0] PAGE_ROW0 = "                     ";
	localparam logic [ROW_BITS-1:0] PAGE_ROW1 = " ERTIOASDGHCBNM>^#  ~";
	localparam logic [ROW_BITS-1:0] PAGE_ROW2 = " QWYUPFJKL  ZXV<^#  ~";
	localparam logic [ROW_BITS-1:0] PAGE_ROW3 = " + ()-/'#@*%!;:>^#,.~";
	localparam logic [ROW_BITS-1:0] PAGE_ROW4 = " ^&[]_ \"{}~ ?<><^#,.~";
	localparam logic [ROW_BITS-1:0] PAGE_ROW5 = " +123-/456*%789>^#0.=";
	localparam logic [ROW_BITS-1:0] PAGE_ROW6 = " ^123e 456  789<^#0.=";

	// char typed by a key on a page; unused pages type a space
	function automatic logic [CHAR_W-1:0] page_char(input logic [PAGE_W-1:0] page,
			input logic [KEY_W-1:0] key);
		logic [ROW_BITS-1:0] row;
		logic [7:0]          c;
		case (page)
			PAGE_1: row = PAGE_ROW1;
			PAGE_2: row = PAGE_ROW2;
			PAGE_3: row = PAGE_ROW3;
			PAGE_4: row = PAGE_ROW4;
			PAGE_5: row = PAGE_ROW5;
			PAGE_6: row = PAGE_ROW6;
			default: row = PAGE_ROW0;
		endcase
		if (int'(key) > MAX_KEY) c = 8'h20;
		else c = row[8*(MAX_KEY - int'(key)) +: 8];
		return c[CHAR_W-1:0];
	endfunction

endpackage

@@ rtl/tkd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tkd_cfg_regs
// Key area and row boundary registers, written through the plain write port.
// ----------------------------------------------------------------------------
module tkd_cfg_regs import tkd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [COORD_W-1:0]   wr_data,
	output tkd_cfg_t             cfg
);

	tkd_cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_area_left    <= COORD_W'(40);
			cfg_q.key_area_right   <= COORD_W'(170);
			cfg_q.row_one_bottom   <= COORD_W'(165);
			cfg_q.row_two_bottom   <= COORD_W'(200);
			cfg_q.row_three_bottom <= COORD_W'(235);
			cfg_q.row_four_bottom  <= COORD_W'(280);
		end else if (wr_en) begin
			case (wr_index)
				CFG_KEY_AREA_LEFT:    cfg_q.key_area_left    <= wr_data;
				CFG_KEY_AREA_RIGHT:   cfg_q.key_area_right   <= wr_data;
				CFG_ROW_ONE_BOTTOM:   cfg_q.row_one_bottom   <= wr_data;
				CFG_ROW_TWO_BOTTOM:   cfg_q.row_two_bottom   <= wr_data;
				CFG_ROW_THREE_BOTTOM: cfg_q.row_three_bottom <= wr_data;
				CFG_ROW_FOUR_BOTTOM:  cfg_q.row_four_bottom  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/tkd_key_pick.sv @@
// ----------------------------------------------------------------------------
// tkd_key_pick
// Maps a touch point to a key index: five columns from the left edge of the
// key area, four rows by y, key zero below the last row.
// ----------------------------------------------------------------------------
module tkd_key_pick import tkd_pkg::*; (
	input  tkd_cfg_t           cfg,
	input  logic [COORD_W-1:0] x_pos,
	input  logic [COORD_W-1:0] y_pos,
	output logic [KEY_W-1:0]   key
);

	logic [COORD_W-1:0] cx;
	logic [COORD_W-1:0] dx;
	logic [2:0]         col;
	logic [1:0]         row;
	logic               below;

	// clamp x into the key area
	always_comb begin
		cx = x_pos;
		if (cx < cfg.key_area_left) cx = cfg.key_area_left;
		if (cx > cfg.key_area_right) cx = cfg.key_area_right;
	end

	// column by threshold compare, capped at the last column
	always_comb begin
		dx  = cx - cfg.key_area_left;
		col = 3'd0;
		if (cx >= cfg.key_area_left) begin
			if (dx >= COORD_W'(MAX_COL) * KEY_WIDTH) col = 3'(MAX_COL);
			else if (dx >= COORD_W'(3) * KEY_WIDTH) col = 3'd3;
			else if (dx >= COORD_W'(2) * KEY_WIDTH) col = 3'd2;
			else if (dx >= KEY_WIDTH) col = 3'd1;
		end
	end

	// first row whose bottom holds y
	always_comb begin
		below = 1'b0;
		row   = 2'd0;
		if (y_pos <= cfg.row_one_bottom) row = 2'd0;
		else if (y_pos <= cfg.row_two_bottom) row = 2'd1;
		else if (y_pos <= cfg.row_three_bottom) row = 2'd2;
		else if (y_pos <= cfg.row_four_bottom) row = 2'd3;
		else below = 1'b1;
	end

	assign key = below ? KEY_NONE
		: ({3'b000, row} * KEY_W'(5) + {2'b00, col} + KEY_W'(1));

endmodule

@@ rtl/tkd_keystroke.sv @@
// ----------------------------------------------------------------------------
// tkd_keystroke
// Holds finger, page and cursor state and turns a key press into one result:
// page switching, delete, typing with page fallback.
// ----------------------------------------------------------------------------
module tkd_keystroke import tkd_pkg::*; #(
	parameter int TEXT_DEPTH = TKD_TEXT_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             contact,
	input  logic [KEY_W-1:0] key,
	output tkd_result_t      result
);

	localparam int CUR_W = $clog2(TEXT_DEPTH + 1);
	localparam int EXT_W = (CUR_W > LEN_W) ? CUR_W : LEN_W;
	localparam logic [CUR_W-1:0] DEPTH_C = CUR_W'(TEXT_DEPTH);

	logic               finger_q;
	logic [PAGE_W-1:0]  page_q;
	logic [CUR_W-1:0]   cursor_q;

	logic               finger_d;
	logic [PAGE_W-1:0]  page_d;
	logic [CUR_W-1:0]   cursor_d;
	logic [CUR_W-1:0]   pos;
	logic [CHAR_W-1:0]  ch;
	logic [CHAR_W-1:0]  typed;
	event_t             ev;
	logic [EXT_W-1:0]   pos_ext;
	logic [EXT_W-1:0]   len_ext;

	// next state and event for the current report
	always_comb begin
		finger_d = finger_q;
		page_d   = page_q;
		cursor_d = cursor_q;
		ev       = EV_NONE;
		ch       = '0;
		pos      = '0;
		typed    = (key == KEY_NONE) ? UNKNOWN_CHAR : page_char(page_q, key);
		if (!finger_q && contact) begin
			finger_d = 1'b1;
			if (key == KEY_TYPE) begin
				ev = EV_PAGE;
				case (page_q)
					PAGE_1, PAGE_2: page_d = PAGE_3;
					PAGE_3, PAGE_4: page_d = PAGE_5;
					PAGE_5, PAGE_6: page_d = PAGE_1;
					default: page_d = page_q;
				endcase
			end else if (key == KEY_PAGE) begin
				ev = EV_PAGE;
				case (page_q)
					PAGE_1: page_d = PAGE_2;
					PAGE_2: page_d = PAGE_1;
					PAGE_3: page_d = PAGE_4;
					PAGE_4: page_d = PAGE_3;
					PAGE_5: page_d = PAGE_6;
					PAGE_6: page_d = PAGE_5;
					default: page_d = page_q;
				endcase
			end else if (key == KEY_DELETE) begin
				if (cursor_q == '0) begin
					ev = EV_EMPTY;
				end else begin
					ev       = EV_DELETE;
					cursor_d = cursor_q - CUR_W'(1);
					pos      = cursor_q - CUR_W'(1);
				end
			end else begin
				// typing, text full leaves the cursor alone
				if (cursor_q >= DEPTH_C) begin
					ev = EV_FULL;
				end else begin
					ev       = EV_CHAR;
					ch       = typed;
					pos      = cursor_q;
					cursor_d = cursor_q + CUR_W'(1);
				end
				// pages fall back after a keystroke
				if (key != KEY_NONE) begin
					case (page_q)
						PAGE_2: page_d = PAGE_1;
						PAGE_6: page_d = PAGE_5;
						PAGE_3, PAGE_4: page_d = PAGE_1;
						default: page_d = page_q;
					endcase
				end
			end
		end else if (finger_q && !contact) begin
			finger_d = 1'b0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finger_q <= 1'b0;
			page_q   <= PAGE_1;
			cursor_q <= '0;
		end else if (step) begin
			finger_q <= finger_d;
			page_q   <= page_d;
			cursor_q <= cursor_d;
		end
	end

	// result fields, cut to the port widths
	assign pos_ext = EXT_W'(pos);
	assign len_ext = EXT_W'(cursor_d);

	assign result.event_kind     = ev;
	assign result.char_code      = ch;
	assign result.write_position = pos_ext[POS_W-1:0];
	assign result.text_length    = len_ext[LEN_W-1:0];
	assign result.page_now       = page_d;

endmodule

@@ rtl/touch_keyboard_decoder.sv @@
// latency: an accepted report passes the input stage and then the result register before its result shows on the output
// throughput: one report per cycle while m_axis_tready holds, set by the single input and result stage
// the input stage takes a new report while a result waits on the output
// reset: finger up, page 1, empty text, key area and rows at their defaults
// ----------------------------------------------------------------------------
// touch_keyboard_decoder
// Turns touch reports into keystrokes on a six-page on-screen keyboard and
// keeps a text cursor; one result per report.
// ----------------------------------------------------------------------------
module touch_keyboard_decoder import tkd_pkg::*; #(
	parameter int TEXT_DEPTH = TKD_TEXT_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_wr_data,
	// touch reports
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,  // x_pos[8:0], y_pos[17:9], zero
	input  logic                 s_axis_tuser,  // contact[0]
	// keystroke results
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [23:0]          m_axis_tdata,  // char_code[6:0], write_position[12:7],
	                                            // text_length[19:13], page_now[22:20], zero
	output logic [2:0]           m_axis_tuser   // event_kind[2:0]
);

	tkd_cfg_t           cfg;
	logic               valid_s1;
	logic               contact_s1;
	logic [COORD_W-1:0] x_s1;
	logic [COORD_W-1:0] y_s1;
	logic [KEY_W-1:0]   key;
	logic               advance;
	tkd_result_t        result;
	tkd_result_t        result_q;
	logic               out_valid_q;

	tkd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_wr_data),
		.cfg      (cfg)
	);

	// handshake: stage 1 moves on when the result register is free
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			contact_s1 <= s_axis_tuser;
			x_s1       <= s_axis_tdata[COORD_W-1:0];
			y_s1       <= s_axis_tdata[2*COORD_W-1:COORD_W];
		end
	end

	tkd_key_pick u_key_pick (
		.cfg   (cfg),
		.x_pos (x_s1),
		.y_pos (y_s1),
		.key   (key)
	);

	tkd_keystroke #(
		.TEXT_DEPTH (TEXT_DEPTH)
	) u_keystroke (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.contact (contact_s1),
		.key     (key),
		.result  (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	// output packing
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = result_q.event_kind;
	assign m_axis_tdata  = {1'b0, result_q.page_now, result_q.text_length,
		result_q.write_position, result_q.char_code};

endmodule
